// ===== rtl/dfs_pkg.sv =====
// Shared types, widths and constants for the Dickey-Fuller statistic block.
// Holds the summary snapshot type, status codes and the back end's micro-program.
// No dependencies.
package dfs_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int DIFF_W     = 21;
  localparam int CNT_W      = 17;
  localparam int SX_W       = 37;
  localparam int SY_W       = 38;
  localparam int SXX_W      = 55;
  localparam int SXY_W      = 57;
  localparam int SYY_W      = 58;
  localparam int OUT_W      = 48;
  localparam int SE_W       = 47;
  localparam int STATUS_W   = 3;
  // wide word covers |Cxy^2*(n-2)| << 48, the largest operand for FRACTION_BITS <= 24
  localparam int BIG_W      = 208;
  localparam int ROOT_W     = BIG_W / 2;
  localparam int ITER_W     = $clog2(BIG_W + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int PC_W       = 6;
  localparam int RF_DEPTH   = 14;
  localparam int RA_W       = $clog2(RF_DEPTH);

  localparam int MAX_PAIRS_DEF     = 65536;
  localparam int FRACTION_BITS_DEF = 16;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic                    overflow;
    logic signed [SX_W-1:0]  sx;
    logic signed [SY_W-1:0]  sy;
    logic signed [SXX_W-1:0] sxx;
    logic signed [SXY_W-1:0] sxy;
    logic signed [SYY_W-1:0] syy;
  } snap_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 3'd0,
    STATUS_FEW   = 3'd1,
    STATUS_FLAT  = 3'd2,
    STATUS_EXACT = 3'd3,
    STATUS_OVF   = 3'd4
  } status_e;

  typedef enum logic [RA_W-1:0] {
    R_N, R_SX, R_SY, R_SXX, R_SXY, R_SYY, R_NM2,
    R_T1, R_T2, R_CXX, R_CXY, R_CYY, R_D, R_DEN
  } reg_e;

  typedef enum logic [2:0] {
    OP_LOAD, OP_MUL, OP_SUB, OP_CHK_CXX, OP_CHK_D, OP_QUO, OP_ROOT, OP_END
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FETCH, BK_EXEC, BK_MUL, BK_DIV, BK_SQRT, BK_DONE
  } bk_state_e;

  localparam logic [1:0] SLOT_ICPT  = 2'd0;
  localparam logic [1:0] SLOT_GAMMA = 2'd1;
  localparam logic [1:0] SLOT_SE    = 2'd2;
  localparam logic [1:0] SLOT_STAT  = 2'd3;

  typedef struct packed {
    op_e        op;
    reg_e       dst;
    reg_e       a;
    reg_e       b;
    logic [1:0] slot;
    logic       cxy_sign;
  } uop_t;

  function automatic uop_t mk(op_e op, reg_e dst, reg_e a, reg_e b,
                              logic [1:0] slot, logic cxy_sign);
    uop_t u;
    u.op       = op;
    u.dst      = dst;
    u.a        = a;
    u.b        = b;
    u.slot     = slot;
    u.cxy_sign = cxy_sign;
    return u;
  endfunction

  function automatic uop_t program_rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_LOAD, R_N,   R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd1:  u = mk(OP_LOAD, R_SX,  R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd2:  u = mk(OP_LOAD, R_SY,  R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd3:  u = mk(OP_LOAD, R_SXX, R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd4:  u = mk(OP_LOAD, R_SXY, R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd5:  u = mk(OP_LOAD, R_SYY, R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd6:  u = mk(OP_LOAD, R_NM2, R_N,   R_N,   SLOT_ICPT, 1'b0);
      6'd7:  u = mk(OP_MUL,  R_T1,  R_N,   R_SXX, SLOT_ICPT, 1'b0);
      6'd8:  u = mk(OP_MUL,  R_T2,  R_SX,  R_SX,  SLOT_ICPT, 1'b0);
      6'd9:  u = mk(OP_SUB,  R_CXX, R_T1,  R_T2,  SLOT_ICPT, 1'b0);
      6'd10: u = mk(OP_MUL,  R_T1,  R_N,   R_SXY, SLOT_ICPT, 1'b0);
      6'd11: u = mk(OP_MUL,  R_T2,  R_SX,  R_SY,  SLOT_ICPT, 1'b0);
      6'd12: u = mk(OP_SUB,  R_CXY, R_T1,  R_T2,  SLOT_ICPT, 1'b0);
      6'd13: u = mk(OP_MUL,  R_T1,  R_N,   R_SYY, SLOT_ICPT, 1'b0);
      6'd14: u = mk(OP_MUL,  R_T2,  R_SY,  R_SY,  SLOT_ICPT, 1'b0);
      6'd15: u = mk(OP_SUB,  R_CYY, R_T1,  R_T2,  SLOT_ICPT, 1'b0);
      6'd16: u = mk(OP_CHK_CXX, R_N, R_CXX, R_CXX, SLOT_ICPT, 1'b0);
      6'd17: u = mk(OP_MUL,  R_T1,  R_CYY, R_CXX, SLOT_ICPT, 1'b0);
      6'd18: u = mk(OP_MUL,  R_T2,  R_CXY, R_CXY, SLOT_ICPT, 1'b0);
      6'd19: u = mk(OP_SUB,  R_D,   R_T1,  R_T2,  SLOT_ICPT, 1'b0);
      6'd20: u = mk(OP_CHK_D, R_N,  R_D,   R_D,   SLOT_ICPT, 1'b0);
      6'd21: u = mk(OP_MUL,  R_T1,  R_SY,  R_CXX, SLOT_ICPT, 1'b0);
      6'd22: u = mk(OP_MUL,  R_T2,  R_CXY, R_SX,  SLOT_ICPT, 1'b0);
      6'd23: u = mk(OP_SUB,  R_T1,  R_T1,  R_T2,  SLOT_ICPT, 1'b0);
      6'd24: u = mk(OP_MUL,  R_DEN, R_N,   R_CXX, SLOT_ICPT, 1'b0);
      6'd25: u = mk(OP_QUO,  R_N,   R_T1,  R_DEN, SLOT_ICPT, 1'b0);
      6'd26: u = mk(OP_QUO,  R_N,   R_CXY, R_CXX, SLOT_GAMMA, 1'b0);
      6'd27: u = mk(OP_MUL,  R_DEN, R_CXX, R_CXX, SLOT_ICPT, 1'b0);
      6'd28: u = mk(OP_MUL,  R_DEN, R_DEN, R_NM2, SLOT_ICPT, 1'b0);
      6'd29: u = mk(OP_ROOT, R_N,   R_D,   R_DEN, SLOT_SE, 1'b0);
      6'd30: u = mk(OP_MUL,  R_T1,  R_CXY, R_CXY, SLOT_ICPT, 1'b0);
      6'd31: u = mk(OP_MUL,  R_T1,  R_T1,  R_NM2, SLOT_ICPT, 1'b0);
      6'd32: u = mk(OP_ROOT, R_N,   R_T1,  R_D,   SLOT_STAT, 1'b1);
      default: u = mk(OP_END, R_N,  R_N,   R_N,   SLOT_ICPT, 1'b0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/dickey_fuller_statistic_top.sv =====
// Dickey-Fuller statistic: accepts one sample per cycle while full is low; sums update from the registered stage 1.
// The time of a full fit after a last sample is set by the bit-serial 208-bit multiplier
// (15 products), four 208-bit divisions and two 104-bit roots; a series with overflow
// or fewer than two pairs skips the fit.
// One finished series can queue behind a running fit; the next last sample holds full high.
// Reset is asynchronous active low; it clears all sums and drops any pending result.
module dickey_fuller_statistic_top #(
  parameter int MAX_PAIRS     = dfs_pkg::MAX_PAIRS_DEF,
  parameter int FRACTION_BITS = dfs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [dfs_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 last_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [dfs_pkg::OUT_W-1:0]     intercept_o,
  output logic signed [dfs_pkg::OUT_W-1:0]     gamma_o,
  output logic [dfs_pkg::SE_W-1:0]             standard_error_o,
  output logic signed [dfs_pkg::OUT_W-1:0]     statistic_o,
  output logic [dfs_pkg::STATUS_W-1:0]         status_o
);

  logic           snap_push, fifo_full, fifo_empty, snap_pop;
  dfs_pkg::snap_t snap_in, snap_head;

  dfs_front #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .full_o      (full),
    .fifo_full_i (fifo_full),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  dfs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (fifo_full),
    .pop_i   (snap_pop),
    .empty_o (fifo_empty),
    .data_o  (snap_head)
  );

  dfs_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (~fifo_empty),
    .snap_i           (snap_head),
    .snap_pop_o       (snap_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .intercept_o      (intercept_o),
    .gamma_o          (gamma_o),
    .standard_error_o (standard_error_o),
    .statistic_o      (statistic_o),
    .status_o         (status_o)
  );

endmodule

// ===== rtl/dfs_front.sv =====
// Front end: pairs each sample with its predecessor and keeps the exact sums.
// On the last sample it hands a snapshot of the sums to the queue and clears.
// Depends on dfs_pkg.
module dfs_front #(
  parameter int MAX_PAIRS = dfs_pkg::MAX_PAIRS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic signed [dfs_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                  last_i,
  output logic                                  full_o,
  input  logic                                  fifo_full_i,
  output logic                                  snap_push_o,
  output dfs_pkg::snap_t                        snap_o
);

  logic                                 stall, accept, fire, take, ovf_hit;
  logic signed [dfs_pkg::SAMPLE_W-1:0]  prev_q;
  logic                                 have_prev_q;
  logic                                 s1_valid_q, s1_last_q, s1_pair_q;
  logic signed [dfs_pkg::SAMPLE_W-1:0]  s1_x_q;
  logic signed [dfs_pkg::DIFF_W-1:0]    s1_y_q, diff;
  logic signed [39:0]                   xx;
  logic signed [40:0]                   xy;
  logic signed [41:0]                   yy;
  logic [dfs_pkg::CNT_W-1:0]            cnt_q, cnt_d;
  logic                                 ovf_q, ovf_d;
  logic signed [dfs_pkg::SX_W-1:0]      sx_q, sx_d;
  logic signed [dfs_pkg::SY_W-1:0]      sy_q, sy_d;
  logic signed [dfs_pkg::SXX_W-1:0]     sxx_q, sxx_d;
  logic signed [dfs_pkg::SXY_W-1:0]     sxy_q, sxy_d;
  logic signed [dfs_pkg::SYY_W-1:0]     syy_q, syy_d;

  // a last item waits in stage 1 until the queue has room
  assign stall  = s1_valid_q & s1_last_q & fifo_full_i;
  assign full_o = stall;
  assign accept = push_i & ~stall;
  assign fire   = s1_valid_q & ~stall;

  assign diff = dfs_pkg::DIFF_W'(sample_i) - dfs_pkg::DIFF_W'(prev_q);

  assign xx = s1_x_q * s1_x_q;
  assign xy = s1_x_q * s1_y_q;
  assign yy = s1_y_q * s1_y_q;

  assign ovf_hit = s1_valid_q & s1_pair_q & (cnt_q >= dfs_pkg::CNT_W'(MAX_PAIRS));
  assign take    = s1_valid_q & s1_pair_q & ~ovf_hit;

  always_comb begin
    cnt_d = take ? cnt_q + dfs_pkg::CNT_W'(1) : cnt_q;
    ovf_d = ovf_q | ovf_hit;
    sx_d  = take ? sx_q  + dfs_pkg::SX_W'(s1_x_q)  : sx_q;
    sy_d  = take ? sy_q  + dfs_pkg::SY_W'(s1_y_q)  : sy_q;
    sxx_d = take ? sxx_q + dfs_pkg::SXX_W'(xx)     : sxx_q;
    sxy_d = take ? sxy_q + dfs_pkg::SXY_W'(xy)     : sxy_q;
    syy_d = take ? syy_q + dfs_pkg::SYY_W'(yy)     : syy_q;
  end

  assign snap_push_o    = fire & s1_last_q;
  assign snap_o.count    = cnt_d;
  assign snap_o.overflow = ovf_d;
  assign snap_o.sx       = sx_d;
  assign snap_o.sy       = sy_d;
  assign snap_o.sxx      = sxx_d;
  assign snap_o.sxy      = sxy_d;
  assign snap_o.syy      = syy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_pair_q   <= 1'b0;
    end else begin
      if (!stall) begin
        s1_valid_q <= accept;
      end
      if (accept) begin
        prev_q      <= sample_i;
        have_prev_q <= ~last_i;
        s1_last_q   <= last_i;
        s1_pair_q   <= have_prev_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q <= prev_q;
      s1_y_q <= diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      syy_q <= '0;
    end else if (fire) begin
      if (s1_last_q) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        sxy_q <= '0;
        syy_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sxx_q <= sxx_d;
        sxy_q <= sxy_d;
        syy_q <= syy_d;
      end
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push_o |-> !fifo_full_i)
    else $error("snapshot pushed into a full queue");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push_o |=> (cnt_q == '0 && !ovf_q && sx_q == '0 && syy_q == '0))
    else $error("sums not cleared after series end");

endmodule

// ===== rtl/dfs_fifo.sv =====
// Short queue of series snapshots between the front and back ends.
// Depends on dfs_pkg.
module dfs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dfs_pkg::snap_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output dfs_pkg::snap_t data_o
);

  localparam int PTR_W = $clog2(dfs_pkg::FIFO_DEPTH);

  dfs_pkg::snap_t        mem [dfs_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]        count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(dfs_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(dfs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(dfs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(dfs_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/dfs_back.sv =====
// Back end: runs the regression fit on one snapshot with a shared shift-add
// multiplier, a restoring divider and a digit-by-digit square root.
// Depends on dfs_pkg.
module dfs_back #(
  parameter int FRACTION_BITS = dfs_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 snap_valid_i,
  input  dfs_pkg::snap_t                       snap_i,
  output logic                                 snap_pop_o,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic signed [dfs_pkg::OUT_W-1:0]     intercept_o,
  output logic signed [dfs_pkg::OUT_W-1:0]     gamma_o,
  output logic [dfs_pkg::SE_W-1:0]             standard_error_o,
  output logic signed [dfs_pkg::OUT_W-1:0]     statistic_o,
  output logic [dfs_pkg::STATUS_W-1:0]         status_o
);

  localparam int W  = dfs_pkg::BIG_W;
  localparam int RW = dfs_pkg::ROOT_W;
  localparam int OW = dfs_pkg::OUT_W;
  localparam int IW = dfs_pkg::ITER_W;

  function automatic logic [OW-1:0] sat(logic [W-1:0] mag, logic neg);
    logic over;
    over = |mag[W-1:OW-1];
    if (neg) begin
      return over ? {1'b1, {(OW-1){1'b0}}} : (~mag[OW-1:0] + OW'(1));
    end
    return over ? {1'b0, {(OW-1){1'b1}}} : mag[OW-1:0];
  endfunction

  dfs_pkg::bk_state_e  state_q, state_d;
  dfs_pkg::status_e    status_q, status_d;
  logic [dfs_pkg::PC_W-1:0] pc_q, pc_d;
  dfs_pkg::uop_t       uop;

  logic [W-1:0]  rf [dfs_pkg::RF_DEPTH];
  logic [W-1:0]  rd_a_q, rd_b_q;
  logic          wr_en;
  logic [W-1:0]  wr_data;

  logic [W-1:0]  mc_q, mc_d, mr_q, mr_d, acc_q, acc_d;
  logic [W-1:0]  quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [RW-1:0] root_q, root_d;
  logic [IW-1:0] iter_q, iter_d;
  logic          sign_q, sign_d, cxy_neg_q, cxy_neg_d;
  logic [OW-1:0] res_q [4];
  logic [OW-1:0] res_d [4];

  logic          out_valid_q, out_load;
  logic [W-1:0]  sub_res, load_val, a_mag, num_sh;
  logic [W:0]    div_t, div_diff;
  logic          div_ge;
  logic [W-1:0]  quo_next, sq_t, sq_trial, sq_diff;
  logic          sq_ge;
  logic [RW-1:0] root_next;
  logic [dfs_pkg::CNT_W-1:0] nm2;

  assign uop = dfs_pkg::program_rom(pc_q);

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf[uop.dst] <= wr_data;
    end
    rd_a_q <= rf[uop.a];
    rd_b_q <= rf[uop.b];
  end

  assign sub_res = rd_a_q - rd_b_q;
  assign nm2     = snap_i.count - dfs_pkg::CNT_W'(2);

  always_comb begin
    unique case (uop.dst)
      dfs_pkg::R_N:   load_val = W'(snap_i.count);
      dfs_pkg::R_SX:  load_val = W'(snap_i.sx);
      dfs_pkg::R_SY:  load_val = W'(snap_i.sy);
      dfs_pkg::R_SXX: load_val = W'(snap_i.sxx);
      dfs_pkg::R_SXY: load_val = W'(snap_i.sxy);
      dfs_pkg::R_SYY: load_val = W'(snap_i.syy);
      dfs_pkg::R_NM2: load_val = W'(nm2);
      default:        load_val = '0;
    endcase
  end

  assign a_mag  = rd_a_q[W-1] ? (~rd_a_q + W'(1)) : rd_a_q;
  assign num_sh = (uop.op == dfs_pkg::OP_ROOT) ? (a_mag << (2 * FRACTION_BITS))
                                               : (a_mag << FRACTION_BITS);

  assign div_t    = {rem_q, quo_q[W-1]};
  assign div_diff = div_t - {1'b0, den_q};
  assign div_ge   = (div_t >= {1'b0, den_q});
  assign quo_next = {quo_q[W-2:0], div_ge};

  assign sq_t      = {rem_q[W-3:0], quo_q[W-1:W-2]};
  assign sq_trial  = W'({root_q, 2'b01});
  assign sq_ge     = (sq_t >= sq_trial);
  assign sq_diff   = sq_t - sq_trial;
  assign root_next = {root_q[RW-2:0], sq_ge};

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    pc_d       = pc_q;
    mc_d       = mc_q;
    mr_d       = mr_q;
    acc_d      = acc_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    den_d      = den_q;
    root_d     = root_q;
    iter_d     = iter_q;
    sign_d     = sign_q;
    cxy_neg_d  = cxy_neg_q;
    res_d      = res_q;
    wr_en      = 1'b0;
    wr_data    = sub_res;
    snap_pop_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      dfs_pkg::BK_IDLE: begin
        if (snap_valid_i) begin
          pc_d = '0;
          priority if (snap_i.overflow) begin
            status_d = dfs_pkg::STATUS_OVF;
            state_d  = dfs_pkg::BK_DONE;
          end else if (snap_i.count < dfs_pkg::CNT_W'(2)) begin
            status_d = dfs_pkg::STATUS_FEW;
            state_d  = dfs_pkg::BK_DONE;
          end else begin
            status_d = dfs_pkg::STATUS_OK;
            state_d  = dfs_pkg::BK_FETCH;
          end
        end
      end
      dfs_pkg::BK_FETCH: begin
        state_d = dfs_pkg::BK_EXEC;
      end
      dfs_pkg::BK_EXEC: begin
        unique case (uop.op)
          dfs_pkg::OP_LOAD: begin
            wr_en   = 1'b1;
            wr_data = load_val;
            pc_d    = pc_q + dfs_pkg::PC_W'(1);
            state_d = dfs_pkg::BK_FETCH;
          end
          dfs_pkg::OP_SUB: begin
            wr_en = 1'b1;
            if (uop.dst == dfs_pkg::R_CXY) begin
              cxy_neg_d = sub_res[W-1];
            end
            pc_d    = pc_q + dfs_pkg::PC_W'(1);
            state_d = dfs_pkg::BK_FETCH;
          end
          dfs_pkg::OP_MUL: begin
            mc_d    = rd_a_q;
            mr_d    = rd_b_q;
            acc_d   = '0;
            state_d = dfs_pkg::BK_MUL;
          end
          dfs_pkg::OP_CHK_CXX: begin
            priority if (rd_a_q == '0) begin
              status_d = dfs_pkg::STATUS_FLAT;
              state_d  = dfs_pkg::BK_DONE;
            end else if (snap_i.count == dfs_pkg::CNT_W'(2)) begin
              status_d = dfs_pkg::STATUS_FEW;
              state_d  = dfs_pkg::BK_DONE;
            end else begin
              pc_d    = pc_q + dfs_pkg::PC_W'(1);
              state_d = dfs_pkg::BK_FETCH;
            end
          end
          dfs_pkg::OP_CHK_D: begin
            if (rd_a_q == '0 || rd_a_q[W-1]) begin
              status_d = dfs_pkg::STATUS_EXACT;
              state_d  = dfs_pkg::BK_DONE;
            end else begin
              pc_d    = pc_q + dfs_pkg::PC_W'(1);
              state_d = dfs_pkg::BK_FETCH;
            end
          end
          dfs_pkg::OP_QUO, dfs_pkg::OP_ROOT: begin
            quo_d   = num_sh;
            rem_d   = '0;
            den_d   = rd_b_q;
            iter_d  = IW'(W);
            sign_d  = uop.cxy_sign ? cxy_neg_q : rd_a_q[W-1];
            state_d = dfs_pkg::BK_DIV;
          end
          dfs_pkg::OP_END: begin
            state_d = dfs_pkg::BK_DONE;
          end
        endcase
      end
      dfs_pkg::BK_MUL: begin
        if (mr_q == '0) begin
          wr_en   = 1'b1;
          wr_data = acc_q;
          pc_d    = pc_q + dfs_pkg::PC_W'(1);
          state_d = dfs_pkg::BK_FETCH;
        end else begin
          acc_d = acc_q + (mr_q[0] ? mc_q : '0);
          mc_d  = mc_q << 1;
          mr_d  = mr_q >> 1;
        end
      end
      dfs_pkg::BK_DIV: begin
        rem_d  = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
        quo_d  = quo_next;
        iter_d = iter_q - IW'(1);
        if (iter_q == IW'(1)) begin
          if (uop.op == dfs_pkg::OP_ROOT) begin
            rem_d   = '0;
            root_d  = '0;
            iter_d  = IW'(RW);
            state_d = dfs_pkg::BK_SQRT;
          end else begin
            res_d[uop.slot] = sat(quo_next, sign_q && (quo_next != '0));
            pc_d    = pc_q + dfs_pkg::PC_W'(1);
            state_d = dfs_pkg::BK_FETCH;
          end
        end
      end
      dfs_pkg::BK_SQRT: begin
        rem_d  = sq_ge ? sq_diff : sq_t;
        root_d = root_next;
        quo_d  = quo_q << 2;
        iter_d = iter_q - IW'(1);
        if (iter_q == IW'(1)) begin
          res_d[uop.slot] = sat(W'(root_next), sign_q && (root_next != '0));
          pc_d    = pc_q + dfs_pkg::PC_W'(1);
          state_d = dfs_pkg::BK_FETCH;
        end
      end
      dfs_pkg::BK_DONE: begin
        if (!out_valid_q || pop_i) begin
          out_load   = 1'b1;
          snap_pop_o = 1'b1;
          state_d    = dfs_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = dfs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfs_pkg::BK_IDLE;
      status_q    <= dfs_pkg::STATUS_OK;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pc_q     <= pc_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q      <= mc_d;
    mr_q      <= mr_d;
    acc_q     <= acc_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    root_q    <= root_d;
    iter_q    <= iter_d;
    sign_q    <= sign_d;
    cxy_neg_q <= cxy_neg_d;
    res_q     <= res_d;
    if (out_load) begin
      status_o <= status_q;
      if (status_q == dfs_pkg::STATUS_OK) begin
        intercept_o      <= res_q[dfs_pkg::SLOT_ICPT];
        gamma_o          <= res_q[dfs_pkg::SLOT_GAMMA];
        standard_error_o <= res_q[dfs_pkg::SLOT_SE][dfs_pkg::SE_W-1:0];
        statistic_o      <= res_q[dfs_pkg::SLOT_STAT];
      end else begin
        intercept_o      <= '0;
        gamma_o          <= '0;
        standard_error_o <= '0;
        statistic_o      <= '0;
      end
    end
  end

  assign empty_o = ~out_valid_q;

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_pop_o |-> snap_valid_i)
    else $error("snapshot popped from an empty queue");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != dfs_pkg::STATUS_OK) |-> (gamma_o == '0 && statistic_o == '0))
    else $error("nonzero values with a failure status");

endmodule

// ===== verif/dickey_fuller_statistic_top_tb.sv =====
// Self-checking testbench for dickey_fuller_statistic_top: streams sample series,
// predicts each fit with exact wide integer math and checks every result item.
// Depends on dfs_pkg and the dickey_fuller_statistic_top RTL.
`timescale 1ns / 1ps

module dickey_fuller_statistic_top_tb;

  localparam int LIM_PAIRS = dfs_pkg::MAX_PAIRS_DEF;
  localparam int FRAC      = dfs_pkg::FRACTION_BITS_DEF;

  typedef logic signed [319:0] wide_t;

  typedef struct {
    logic [dfs_pkg::SAMPLE_W-1:0] smp;
    logic                         lst;
    logic                         nogap;
    logic                         drain;
  } sample_item_t;

  typedef struct {
    logic [dfs_pkg::OUT_W-1:0]    icpt;
    logic [dfs_pkg::OUT_W-1:0]    gam;
    logic [dfs_pkg::SE_W-1:0]     se;
    logic [dfs_pkg::OUT_W-1:0]    tstat;
    logic [dfs_pkg::STATUS_W-1:0] st;
  } fit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [dfs_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic last_i = 1'b0;
  logic full, empty;
  logic signed [dfs_pkg::OUT_W-1:0] intercept_o, gamma_o, statistic_o;
  logic [dfs_pkg::SE_W-1:0] standard_error_o;
  logic [dfs_pkg::STATUS_W-1:0] status_o;

  always #1 clk_i = ~clk_i;

  dickey_fuller_statistic_top u_top (
    .clk_i, .rst_ni, .push, .full, .sample_i, .last_i,
    .empty, .pop, .intercept_o, .gamma_o, .standard_error_o, .statistic_o, .status_o
  );

  sample_item_t pending_samples[$];
  fit_t         expected_fits[$];
  sample_item_t cur;
  int  mismatches = 0;
  int  samples_in = 0, fits_out = 0;
  int  status_seen[5] = '{default: 0};
  bit  quiet = 1'b0;

  // running sums of the current series
  logic signed [dfs_pkg::SAMPLE_W-1:0] prev_smp;
  bit     have_prev, too_long;
  int     pairs;
  longint s_x, s_y, s_xx, s_xy, s_yy;

  function automatic wide_t isqrt(wide_t a);
    wide_t r, c;
    r = '0;
    for (int i = 159; i >= 0; i--) begin
      c = r | (wide_t'(1) << i);
      if (c * c <= a) r = c;
    end
    return r;
  endfunction

  function automatic logic [dfs_pkg::OUT_W-1:0] clamp48(wide_t q, bit neg);
    if (q >= (wide_t'(1) <<< 47)) return neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    return neg ? -q[dfs_pkg::OUT_W-1:0] : q[dfs_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [dfs_pkg::OUT_W-1:0] trunc_quot(wide_t num, wide_t den);
    wide_t mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FRAC) / den;
    return clamp48(q, num < 0 && q != 0);
  endfunction

  function automatic fit_t fit_series();
    fit_t  f;
    wide_t n, sx, sy, cxx, cxy, cyy, d, nm2, q;
    logic [dfs_pkg::OUT_W-1:0] se_full;
    f = '{default: '0};
    f.st = dfs_pkg::STATUS_OK;
    n = wide_t'(pairs); sx = wide_t'(s_x); sy = wide_t'(s_y); nm2 = wide_t'(pairs - 2);
    cxx = n * wide_t'(s_xx) - sx * sx;
    cxy = n * wide_t'(s_xy) - sx * sy;
    cyy = n * wide_t'(s_yy) - sy * sy;
    d = cyy * cxx - cxy * cxy;
    if (too_long) f.st = dfs_pkg::STATUS_OVF;
    else if (pairs < 2) f.st = dfs_pkg::STATUS_FEW;
    else if (cxx == 0) f.st = dfs_pkg::STATUS_FLAT;
    else if (pairs == 2) f.st = dfs_pkg::STATUS_FEW;
    else if (d <= 0) f.st = dfs_pkg::STATUS_EXACT;
    if (f.st != dfs_pkg::STATUS_OK) return f;
    f.icpt = trunc_quot(sy * cxx - cxy * sx, n * cxx);
    f.gam  = trunc_quot(cxy, cxx);
    q = isqrt((d <<< (2 * FRAC)) / (cxx * cxx * nm2));
    se_full = clamp48(q, 1'b0);
    f.se = se_full[dfs_pkg::SE_W-1:0];
    q = isqrt(((cxy * cxy * nm2) <<< (2 * FRAC)) / d);
    f.tstat = clamp48(q, cxy < 0 && q != 0);
    return f;
  endfunction

  task automatic clear_series();
    prev_smp = '0; have_prev = 0; too_long = 0; pairs = 0;
    s_x = 0; s_y = 0; s_xx = 0; s_xy = 0; s_yy = 0;
  endtask

  task automatic take_sample(logic signed [dfs_pkg::SAMPLE_W-1:0] s, logic lst);
    longint x, y;
    if (have_prev) begin
      if (pairs >= LIM_PAIRS) too_long = 1;
      else begin
        x = prev_smp; y = longint'(s) - x;
        pairs++;
        s_x += x; s_y += y; s_xx += x * x; s_xy += x * y; s_yy += y * y;
      end
    end
    prev_smp = s; have_prev = 1;
    if (lst) begin
      expected_fits.push_back(fit_series());
      clear_series();
    end
  endtask

  // driver
  bit in_took = 0;
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      take_sample(sample_i, last_i);
      samples_in++;
      in_took = 1;
      if (samples_in % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
    end
  end

  always @(negedge clk_i) begin
    logic nxt;
    nxt = push;
    if (in_took) begin
      in_took = 0;
      nxt = 0;
      in_gap = (quiet || cur.nogap) ? 0 : $urandom_range(0, 5);
    end
    if (rst_ni && !nxt) begin
      if (in_gap > 0) in_gap--;
      else if (pending_samples.size() > 0 &&
               !(pending_samples[0].drain && expected_fits.size() > 0)) begin
        cur = pending_samples.pop_front();
        sample_i <= cur.smp;
        last_i   <= cur.lst;
        nxt = 1;
      end
    end
    push <= nxt;
  end

  // result side
  bit out_took = 0;
  int out_gap = 0;
  always @(posedge clk_i) begin
    fit_t e;
    if (rst_ni && pop && !empty) begin
      out_took = 1;
      fits_out++;
      if (status_o <= dfs_pkg::STATUS_OVF) status_seen[status_o]++;
      if (expected_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item, status %0d", status_o);
      end else begin
        e = expected_fits.pop_front();
        if (e.icpt !== intercept_o || e.gam !== gamma_o || e.se !== standard_error_o ||
            e.tstat !== statistic_o || e.st !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"fit %0d mismatch: exp a=%h g=%h se=%h t=%h st=%0d",
                      " / got a=%h g=%h se=%h t=%h st=%0d"},
                     fits_out, e.icpt, e.gam, e.se, e.tstat, e.st, intercept_o, gamma_o,
                     standard_error_o, statistic_o, status_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_took) begin
      out_took = 0;
      out_gap = quiet ? 0 : $urandom_range(0, 5);
    end
    if (out_gap > 0) begin
      out_gap--;
      pop <= 1'b0;
    end else pop <= rst_ni;
  end

  task automatic add(int s, bit lst, bit drain = 0, bit nogap = 0);
    sample_item_t it;
    it.smp = s[dfs_pkg::SAMPLE_W-1:0]; it.lst = lst; it.nogap = nogap; it.drain = drain;
    pending_samples.push_back(it);
  endtask

  task automatic add_series(int vals[$], bit drain = 0);
    foreach (vals[i]) add(vals[i], i == vals.size() - 1, drain && i == 0);
  endtask

  initial begin
    int len, v, kind, total;
    clear_series();
    // directed series
    add_series('{123});                                  // single sample
    add_series('{5, -7});                                // one pair
    add_series('{9, 9, 9});                              // flat lag
    add_series('{1, 4, -2});                             // exactly two pairs
    add_series('{1, 2, 3, 4}, 1);                        // perfect fit, zero error
    add_series('{-524288, 524287, -524288, 524287, 0});  // field extremes
    add_series('{524287, 524287, 524286, 524287, -1});
    add_series('{10, 13, 11, 17, 12, 20});
    // random series
    total = 0;
    while (total < 480) begin
      kind = $urandom_range(0, 9);
      len = (kind == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      v = $urandom_range(0, 1048575) - 524288;
      for (int i = 0; i < len; i++) begin
        if (kind < 4) v = $urandom_range(0, 1048575) - 524288;
        else if (kind < 8) v = v + $urandom_range(0, 200) - 100;
        else v = (i % 3) * 7 + $urandom_range(0, 1);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        add(v, i == len - 1, i == 0 && $urandom_range(0, 30) == 0);
      end
      total += len;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_samples.size() > 0 || push) @(posedge clk_i);
    while (expected_fits.size() > 0) @(posedge clk_i);
    repeat (5000) @(posedge clk_i);
    if (expected_fits.size() > 0) mismatches++;
    $display("%0d samples in directed and random series, %0d fits checked",
             samples_in, fits_out);
    $display("status mix: ok %0d, few %0d, flat %0d, exact %0d, overflow %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) $display("** dickey_fuller_statistic_top: PASSED **");
    else $display("** dickey_fuller_statistic_top: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** dickey_fuller_statistic_top: FAILED **");
    $finish;
  end

endmodule
